FILE: rtl/sf_pkg.sv
// sf_pkg: shared types and constants of the stereo flanger
// step codes, register indexes and controller/datapath command structs
// no dependencies
package sf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIX       = 3'd7;

  // datapath steps, each one multiply followed by one write-back
  typedef enum logic [4:0] {
    OP_SQ  = 5'd0,
    OP_IN  = 5'd1,
    OP_MID = 5'd2,
    OP_QS  = 5'd3,
    OP_BL1 = 5'd4,
    OP_BL2 = 5'd5,
    OP_SW  = 5'd6,
    OP_FB  = 5'd7,
    OP_RD0 = 5'd8,
    OP_RD1 = 5'd9,
    OP_RD2 = 5'd10,
    OP_RD3 = 5'd11,
    OP_C1  = 5'd12,
    OP_C2  = 5'd13,
    OP_C3  = 5'd14,
    OP_D1  = 5'd15,
    OP_D2  = 5'd16,
    OP_O1  = 5'd17,
    OP_O2  = 5'd18,
    OP_O3  = 5'd19
  } op_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
    logic wb;
    op_t  op;
    logic ch;
  } sf_cmd_t;

  typedef struct packed {
    logic clr_last;
  } sf_stat_t;

endpackage

FILE: rtl/sf_if.sv
// sf_if: valid/ready channel interfaces of the stereo flanger
// input pair channel and output pair channel, no dependencies
interface sf_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sf_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: rtl/sf_ram.sv
// sf_ram: generic single write port, single read port ram
// registered read data, no dependencies
module sf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sf_ctrl.sv
// sf_ctrl: sequencer of the stereo flanger
// steps the datapath through clearing, per channel work and mixing; uses sf_pkg
module sf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sf_pkg::sf_cmd_t  cmd,
  input  sf_pkg::sf_stat_t stat
);
  import sf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RUN   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   ch_r, ch_nxt;
  logic   ph_r, ph_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ch_nxt     = ch_r;
    ph_nxt     = ph_r;
    ov_nxt     = ov_r && !out_ready;
    cmd        = '0;
    cmd.op     = op_r;
    cmd.ch     = ch_r;
    in_ready   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
          op_nxt    = OP_SQ;
          ch_nxt    = 1'b0;
          ph_nxt    = 1'b0;
        end
      end
      S_RUN: begin
        cmd.wb = ph_r;
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (op_r == OP_D2) begin
            ch_nxt = !ch_r;
            op_nxt = ch_r ? OP_O1 : OP_SQ;
          end else if (op_r == OP_O3) begin
            ch_nxt = !ch_r;
            op_nxt = OP_O1;
            if (ch_r) begin
              state_nxt = S_DONE;
            end
          end else begin
            op_nxt = op_t'(op_r + 5'd1);
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.commit = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= OP_SQ;
      ch_r    <= 1'b0;
      ph_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ch_r    <= ch_nxt;
      ph_r    <= ph_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

FILE: rtl/sf_dp.sv
// sf_dp: datapath of the stereo flanger
// config registers, lfo, delay rams, one shared multiplier; uses sf_pkg and sf_ram
module sf_dp #(
  parameter int DELAY_DEPTH      = 2048,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sf_pkg::sf_cmd_t                     cmd,
  output sf_pkg::sf_stat_t                    stat,
  input  logic                                cfg_we,
  input  logic [sf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [sf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]      left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]      right_in,
  output logic signed [SAMPLE_WIDTH-1:0]      left_out,
  output logic signed [SAMPLE_WIDTH-1:0]      right_out
);
  import sf_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int DW  = SW + 8;
  localparam int AW  = SW + 14;
  localparam int BW  = 28;
  localparam int PW  = AW + BW;
  localparam int AWD = $clog2(DELAY_DEPTH);
  localparam int STL = $clog2(SINE_TABLE_DEPTH);

  localparam logic [33:0] DLIM = 34'(DELAY_DEPTH - 2) << 16;
  localparam logic signed [PW-1:0] SMAX = PW'((longint'(1) <<< (SW - 1)) - 1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
  localparam logic signed [PW-1:0] AMAX = PW'((longint'(1) <<< (DW - 1)) - 1);
  localparam logic signed [PW-1:0] AMIN = -AMAX - PW'(1);
  localparam logic [AWD-1:0] LAST = AWD'(DELAY_DEPTH - 1);

  // configuration
  logic [31:0]        inc_r, off_r;
  logic [26:0]        base_r, sweep_r;
  logic signed [15:0] fb_r;
  logic [15:0]        alpha_r;
  logic [16:0]        shape_r;
  logic [47:0]        mix_r;

  // item state
  logic [AWD-1:0]        wp_r, clr_r;
  logic [31:0]           phase_r;
  logic signed [DW-1:0]  damp_l_r, damp_rt_r;
  logic signed [SW-1:0]  in_l_r, in_rt_r;
  logic signed [SW-1:0]  res_l_r, res_rt_r, out_l_r, out_rt_r;

  // intermediates
  logic [16:0]           t2_r, inner_r, mid_r, sine_r, lfo_r;
  logic [AWD-1:0]        id_r;
  logic [15:0]           f_r;
  logic signed [SW-1:0]  y0_r, y1_r, y2_r, y3_r;
  logic signed [AW-1:0]  t_r;
  logic signed [DW-1:0]  rd_r;
  logic signed [PW-1:0]  p_r, acc_r;

  // lfo phase and shape terms
  logic [31:0] ph_c;
  logic [17:0] u;
  logic [1:0]  q;
  logic [16:0] tq, tri_w, sh, s_w;
  logic [17:0] tw2, tri18;

  always_comb begin
    ph_c  = phase_r + (cmd.ch ? off_r : 32'd0);
    u     = {ph_c[31 -: STL], {(18 - STL){1'b0}}};
    q     = u[17:16];
    tq    = q[0] ? 17'd65536 - {1'b0, u[15:0]} : {1'b0, u[15:0]};
    tw2   = {1'b0, ph_c[31:16], 1'b0};
    case (ph_c[31:30])
      2'b00:   tri18 = 18'd32768 + tw2;
      2'b11:   tri18 = tw2 - 18'd98304;
      default: tri18 = 18'd98304 - tw2;
    endcase
    tri_w = tri18[16:0];
    sh    = (shape_r > 17'd65536) ? 17'd65536 : shape_r;
  end

  // interpolation taps and coefficients
  logic signed [AW-1:0]  y0s, y1s, y2s, y3s, a2, b2, c2;
  logic signed [DW-1:0]  st_c, own_c, oth_c;
  logic signed [SW-1:0]  in_c, yd;
  logic signed [SW-1:0]  rdat_l, rdat_rt;

  always_comb begin
    y0s   = AW'(y0_r) <<< 8;
    y1s   = AW'(y1_r) <<< 8;
    y2s   = AW'(y2_r) <<< 8;
    y3s   = AW'(y3_r) <<< 8;
    a2    = -y0s + ((y1s <<< 1) + y1s) - ((y2s <<< 1) + y2s) + y3s;
    b2    = (y0s <<< 1) - ((y1s <<< 2) + y1s) + (y2s <<< 2) - y3s;
    c2    = y2s - y0s;
    st_c  = cmd.ch ? damp_rt_r : damp_l_r;
    own_c = st_c;
    oth_c = cmd.ch ? damp_l_r : damp_rt_r;
    in_c  = cmd.ch ? in_rt_r : in_l_r;
    yd    = cmd.ch ? rdat_rt : rdat_l;
  end

  // shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  always_comb begin
    case (cmd.op)
      OP_SQ:   begin mul_a = AW'(tq);      mul_b = BW'(tq); end
      OP_IN:   begin mul_a = AW'(t2_r);    mul_b = BW'(17'd4640); end
      OP_MID:  begin mul_a = AW'(t2_r);    mul_b = BW'(inner_r); end
      OP_QS:   begin mul_a = AW'(tq);      mul_b = BW'(mid_r); end
      OP_BL1:  begin mul_a = AW'(sine_r);  mul_b = BW'(17'd65536 - sh); end
      OP_BL2:  begin mul_a = AW'(tri_w);   mul_b = BW'(sh); end
      OP_SW:   begin mul_a = AW'(lfo_r);   mul_b = BW'(sweep_r); end
      OP_FB:   begin mul_a = AW'(st_c);    mul_b = BW'(fb_r); end
      OP_C1:   begin mul_a = a2;           mul_b = BW'({1'b0, f_r}); end
      OP_C2:   begin mul_a = t_r;          mul_b = BW'({1'b0, f_r}); end
      OP_C3:   begin mul_a = t_r;          mul_b = BW'({1'b0, f_r}); end
      OP_D1:   begin mul_a = AW'(st_c);    mul_b = BW'({1'b0, alpha_r}); end
      OP_D2:   begin mul_a = AW'(rd_r);    mul_b = BW'(17'd65536 - {1'b0, alpha_r}); end
      OP_O1:   begin mul_a = AW'(in_c) <<< 8; mul_b = BW'($signed(mix_r[15:0])); end
      OP_O2:   begin mul_a = AW'(own_c);   mul_b = BW'($signed(mix_r[31:16])); end
      OP_O3:   begin mul_a = AW'(oth_c);   mul_b = BW'($signed(mix_r[47:32])); end
      default: begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  // write-back values
  logic signed [PW-1:0] sum_ap, fbv, rdv, outv, p16;
  logic [33:0]          dsum, dcl;
  logic signed [SW-1:0] wsat, osat;
  logic signed [DW-1:0] rsat;

  always_comb begin
    sum_ap = acc_r + p_r;
    p16    = p_r >>> 16;
    s_w    = (p16 > PW'(65536)) ? 17'd65536 : p16[16:0];
    dsum   = 34'(base_r) + p16[33:0];
    dcl    = (dsum > DLIM) ? DLIM : dsum;
    fbv    = PW'(in_c) + (p_r >>> 22);
    wsat   = (fbv > SMAX) ? SMAX[SW-1:0] : ((fbv < SMIN) ? SMIN[SW-1:0] : fbv[SW-1:0]);
    rdv    = PW'(y1s) + (p_r >>> 17);
    rsat   = (rdv > AMAX) ? AMAX[DW-1:0] : ((rdv < AMIN) ? AMIN[DW-1:0] : rdv[DW-1:0]);
    outv   = sum_ap >>> 22;
    osat   = (outv > SMAX) ? SMAX[SW-1:0] : ((outv < SMIN) ? SMIN[SW-1:0] : outv[SW-1:0]);
  end

  // tap addresses
  logic [AWD:0]   bsum;
  logic [AWD-1:0] tb, ta0, ta2, ta3, raddr;

  always_comb begin
    bsum = {1'b0, wp_r} + (AWD + 1)'(DELAY_DEPTH) - {1'b0, id_r};
    tb   = (bsum >= (AWD + 1)'(DELAY_DEPTH)) ?
           AWD'(bsum - (AWD + 1)'(DELAY_DEPTH)) : bsum[AWD-1:0];
    ta0  = (tb == LAST) ? '0 : tb + AWD'(1);
    ta2  = (tb == '0) ? LAST : tb - AWD'(1);
    ta3  = (tb >= AWD'(2)) ? tb - AWD'(2) : tb + AWD'(DELAY_DEPTH - 2);
    case (cmd.op)
      OP_RD0:  raddr = ta0;
      OP_RD1:  raddr = tb;
      OP_RD2:  raddr = ta2;
      OP_RD3:  raddr = ta3;
      default: raddr = tb;
    endcase
  end

  // delay rams
  logic                 we_l, we_rt, fb_wr;
  logic [AWD-1:0]       waddr;
  logic [SW-1:0]        wdata, rd_l_raw, rd_rt_raw;

  assign fb_wr = cmd.wb && (cmd.op == OP_FB);
  assign we_l  = cmd.clear || (fb_wr && !cmd.ch);
  assign we_rt = cmd.clear || (fb_wr && cmd.ch);
  assign waddr = cmd.clear ? clr_r : wp_r;
  assign wdata = cmd.clear ? '0 : wsat;
  assign rdat_l  = $signed(rd_l_raw);
  assign rdat_rt = $signed(rd_rt_raw);

  sf_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_l (
    .clk, .we(we_l), .waddr, .wdata, .raddr, .rdata(rd_l_raw)
  );

  sf_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_r (
    .clk, .we(we_rt), .waddr, .wdata, .raddr, .rdata(rd_rt_raw)
  );

  assign stat.clr_last = (clr_r == LAST);
  assign left_out      = out_l_r;
  assign right_out     = out_rt_r;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r     <= 32'd447392;
      off_r     <= '0;
      base_r    <= '0;
      sweep_r   <= '0;
      fb_r      <= '0;
      alpha_r   <= '0;
      shape_r   <= '0;
      mix_r     <= 48'd16384;
      wp_r      <= '0;
      clr_r     <= '0;
      phase_r   <= '0;
      damp_l_r  <= '0;
      damp_rt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PHASE_INC: inc_r   <= cfg_data[31:0];
          REG_PHASE_OFF: off_r   <= cfg_data[31:0];
          REG_BASE_DLY:  base_r  <= cfg_data[26:0];
          REG_SWEEP:     sweep_r <= cfg_data[26:0];
          REG_FB_GAIN:   fb_r    <= $signed(cfg_data[15:0]);
          REG_DAMP:      alpha_r <= cfg_data[15:0];
          REG_SHAPE:     shape_r <= cfg_data[16:0];
          REG_MIX:       mix_r   <= cfg_data[47:0];
          default:       ;
        endcase
      end
      if (cmd.clear) begin
        clr_r <= clr_r + AWD'(1);
      end
      if (cmd.wb && (cmd.op == OP_D2)) begin
        if (cmd.ch) begin
          damp_rt_r <= sum_ap[16 +: DW];
        end else begin
          damp_l_r <= sum_ap[16 +: DW];
        end
      end
      if (cmd.commit) begin
        wp_r    <= (wp_r == LAST) ? '0 : wp_r + AWD'(1);
        phase_r <= phase_r + inc_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (cmd.load) begin
      in_l_r  <= left_in;
      in_rt_r <= right_in;
    end
    if (cmd.commit) begin
      out_l_r  <= res_l_r;
      out_rt_r <= res_rt_r;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_SQ:  t2_r    <= p16[16:0];
        OP_IN:  inner_r <= 17'd42048 - p16[16:0];
        OP_MID: mid_r   <= 17'd102944 - p16[16:0];
        OP_QS:  sine_r  <= (q < 2'd2) ? 17'd32768 + (s_w >> 1) : 17'd32768 - (s_w >> 1);
        OP_BL1: acc_r   <= p_r;
        OP_BL2: lfo_r   <= sum_ap[32:16];
        OP_SW: begin
          id_r <= dcl[16 +: AWD];
          f_r  <= dcl[15:0];
        end
        OP_RD0: y0_r <= yd;
        OP_RD1: y1_r <= yd;
        OP_RD2: y2_r <= yd;
        OP_RD3: y3_r <= yd;
        OP_C1:  t_r  <= AW'(p16 + PW'(b2));
        OP_C2:  t_r  <= AW'(p16 + PW'(c2));
        OP_C3:  rd_r <= rsat;
        OP_D1:  acc_r <= p_r;
        OP_O1:  acc_r <= p_r;
        OP_O2:  acc_r <= sum_ap;
        OP_O3: begin
          if (cmd.ch) begin
            res_rt_r <= osat;
          end else begin
            res_l_r <= osat;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/stereo_flanger.sv
// stereo_flanger: top level of the stereo flanger
// joins sf_ctrl and sf_dp; uses sf_pkg and the channel interfaces in sf_if
//
// One stereo pair goes in per transaction and one mixed pair comes out. After reset the
// block first zeroes both delay memories, one entry per cycle, with in_ch.ready low
// (configuration writes are taken meanwhile). An item then runs through 40 steps on one
// shared multiplier, each a multiply and a write-back (17 per channel for lfo, write,
// four delay reads, cubic read and damping, then three per channel for the mix), and
// the block takes a new pair only after the last one has finished all its steps. A
// finished result sits in the output register while the next item is taken. The user
// must write configuration only while the block is idle; the block does not enforce it.
module stereo_flanger #(
  parameter int DELAY_DEPTH      = 2048,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sf_in_if.sink                         in_ch,
  sf_out_if.source                      out_ch,
  input  logic                          cfg_we,
  input  logic [sf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sf_pkg::*;

  sf_cmd_t  cmd;
  sf_stat_t stat;

  sf_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd,
    .stat
  );

  sf_dp #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk,
    .rst_n,
    .cmd,
    .stat,
    .cfg_we,
    .cfg_idx,
    .cfg_data,
    .left_in  (in_ch.left_in),
    .right_in (in_ch.right_in),
    .left_out (out_ch.left_out),
    .right_out(out_ch.right_out)
  );
endmodule

FILE: rtl/sf_checker.sv
// sf_checker: port level checks of the stereo flanger
// bound to stereo_flanger; no other dependencies
module sf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // clearing pass after reset
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during memory clear");

  // result appears only from the busy state
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a finished item");
endmodule

bind stereo_flanger sf_checker u_sf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (64'({out_ch.left_out, out_ch.right_out}))
);

FILE: test/stereo_flanger_tb.sv
// stereo_flanger_tb: self-checking testbench of the stereo flanger
// drives sample pairs through sf_in_if, checks mixed pairs on sf_out_if against
// a cycle-free model of the flanger; uses sf_pkg, sf_if and stereo_flanger
`timescale 1ns / 100ps

module stereo_flanger_tb;
  import sf_pkg::*;

  localparam int DEPTH   = 2048;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam longint AMAX = SMAX * 256 + 255;
  localparam longint AMIN = SMIN * 256;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sf_in_if #(.SAMPLE_WIDTH(16)) in_ch ();
  sf_out_if #(.SAMPLE_WIDTH(16)) out_ch ();

  stereo_flanger i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // flanger model state
  logic signed [15:0] left_line [DEPTH];
  logic signed [15:0] right_line [DEPTH];
  int unsigned wr_pos;
  logic [31:0] lfo_ph;
  longint damp_l, damp_r;
  logic [31:0] m_phase_inc, m_phase_off;
  logic [26:0] m_base, m_sweep;
  logic signed [15:0] m_fb;
  logic [15:0] m_alpha;
  logic [16:0] m_shape;
  logic [47:0] m_mix;

  pair_t expected_pairs[$];
  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("stereo_flanger_tb: FAIL");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_sine(longint t);
    longint t2, inner, mid;
    t2 = (t * t) >>> 16;
    inner = 42048 - ((t2 * 4640) >>> 16);
    mid = 102944 - ((t2 * inner) >>> 16);
    return clamp((t * mid) >>> 16, 0, 65536);
  endfunction

  function automatic longint lfo_at(logic [31:0] ph);
    longint u, t, s, q, p16, tri_v, sh;
    u = longint'(ph >> 22) * 256;
    q = (u >> 16) & 3;
    t = u & 'hFFFF;
    s = (q & 1) ? quarter_sine(65536 - t) : quarter_sine(t);
    s = q < 2 ? 32768 + (s >>> 1) : 32768 - (s >>> 1);
    p16 = longint'(ph >> 16);
    if (ph < 32'h4000_0000) tri_v = 32768 + 2 * p16;
    else if (ph < 32'hC000_0000) tri_v = 98304 - 2 * p16;
    else tri_v = 2 * p16 - 98304;
    sh = m_shape > 17'd65536 ? 65536 : longint'(m_shape);
    return (s * (65536 - sh) + tri_v * sh) >>> 16;
  endfunction

  function automatic longint delay_at(longint lfo);
    longint d;
    d = longint'(m_base) + ((lfo * longint'(m_sweep)) >>> 16);
    return d > (longint'(DEPTH - 2) << 16) ? (longint'(DEPTH - 2) << 16) : d;
  endfunction

  function automatic longint interp_read(bit right_side, longint d);
    longint id, f, b, y0, y1, y2, y3, a2, b2, c2, t;
    id = d >>> 16;
    f = d & 'hFFFF;
    b = wr_pos + 2 * DEPTH - id;
    if (right_side) begin
      y0 = right_line[(b + 1) % DEPTH] * 256;
      y1 = right_line[b % DEPTH] * 256;
      y2 = right_line[(b - 1) % DEPTH] * 256;
      y3 = right_line[(b - 2) % DEPTH] * 256;
    end else begin
      y0 = left_line[(b + 1) % DEPTH] * 256;
      y1 = left_line[b % DEPTH] * 256;
      y2 = left_line[(b - 1) % DEPTH] * 256;
      y3 = left_line[(b - 2) % DEPTH] * 256;
    end
    a2 = -y0 + 3 * y1 - 3 * y2 + y3;
    b2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c2 = -y0 + y2;
    t = ((a2 * f) >>> 16) + b2;
    t = ((t * f) >>> 16) + c2;
    t = (t * f) >>> 17;
    return clamp(y1 + t, AMIN, AMAX);
  endfunction

  function automatic longint damp_next(longint st, longint x);
    longint a;
    a = longint'(m_alpha);
    return (a * st + (65536 - a) * x) >>> 16;
  endfunction

  function automatic pair_t flange(pair_t smp);
    longint inl, inr, dry, wet, crs, dl, dr, wl, wr, ol, orr;
    pair_t res;
    inl = smp.left;
    inr = smp.right;
    dry = longint'($signed(m_mix[15:0]));
    wet = longint'($signed(m_mix[31:16]));
    crs = longint'($signed(m_mix[47:32]));
    dl = delay_at(lfo_at(lfo_ph));
    dr = delay_at(lfo_at(lfo_ph + m_phase_off));
    wl = inl + ((longint'(m_fb) * damp_l) >>> 22);
    wr = inr + ((longint'(m_fb) * damp_r) >>> 22);
    left_line[wr_pos] = 16'(clamp(wl, SMIN, SMAX));
    right_line[wr_pos] = 16'(clamp(wr, SMIN, SMAX));
    damp_l = damp_next(damp_l, interp_read(1'b0, dl));
    damp_r = damp_next(damp_r, interp_read(1'b1, dr));
    ol = (dry * inl * 256 + wet * damp_l + crs * damp_r) >>> 22;
    orr = (dry * inr * 256 + wet * damp_r + crs * damp_l) >>> 22;
    res.left = 16'(clamp(ol, SMIN, SMAX));
    res.right = 16'(clamp(orr, SMIN, SMAX));
    wr_pos = (wr_pos + 1) % DEPTH;
    lfo_ph = lfo_ph + m_phase_inc;
    return res;
  endfunction

  task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        $display("unexpected transaction at %0t", $time);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_ch.left_out !== want.left) report("left_out", out_ch.left_out, want.left);
        if (out_ch.right_out !== want.right) report("right_out", out_ch.right_out, want.right);
      end
    end
  end

  // receiver with random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
    pair_t smp;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    smp.left = l;
    smp.right = r;
    expected_pairs.push_back(flange(smp));
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (expected_pairs.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_INC: m_phase_inc = val[31:0];
      REG_PHASE_OFF: m_phase_off = val[31:0];
      REG_BASE_DLY:  m_base = val[26:0];
      REG_SWEEP:     m_sweep = val[26:0];
      REG_FB_GAIN:   m_fb = val[15:0];
      REG_DAMP:      m_alpha = val[15:0];
      REG_SHAPE:     m_shape = val[16:0];
      REG_MIX:       m_mix = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] inc, logic [31:0] off, logic [26:0] base,
                         logic [26:0] sweep, logic [15:0] fb, logic [15:0] alpha,
                         logic [16:0] shape, logic [47:0] mix);
    drain();
    write_reg(REG_PHASE_INC, inc);
    write_reg(REG_PHASE_OFF, off);
    write_reg(REG_BASE_DLY, base);
    write_reg(REG_SWEEP, sweep);
    write_reg(REG_FB_GAIN, fb);
    write_reg(REG_DAMP, alpha);
    write_reg(REG_SHAPE, shape);
    write_reg(REG_MIX, mix);
  endtask

  // reset settings, zero delay so the newest tap wraps
  task automatic test_reset_settings;
    send_pair(16'sh7FFF, -16'sh8000);
    send_pair(-16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, 16'shFFFF);
    send_pair(16'sh1234, -16'sh1234);
  endtask

  // saturation of stores, reads and outputs
  task automatic test_extremes;
    set_all(32'h4000_0000, 32'h8000_0000, 27'd150000, 27'd70000, 16'sh4000,
            16'd0, 17'h1FFFF, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    for (int i = 0; i < 8; i++)
      send_pair(i[0] ? 16'sh7FFF : -16'sh8000, i[0] ? -16'sh8000 : 16'sh7FFF);
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'd134086656, 27'h7FF_FFFF, -16'sh4000,
            16'hFFFF, 17'd65536, {16'h8000, 16'h8000, 16'h8000});
    for (int i = 0; i < 6; i++) send_pair(16'sh7FFF, -16'sh8000);
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure;
    set_all(32'd447392, 32'h2000_0000, 27'd200000, 27'd100000, 16'sh2000,
            16'd30000, 17'd32768, {16'sh2000, 16'sh2000, 16'sh1000});
    src_idle = 0;
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_pair(16'($urandom), 16'($urandom));
  endtask

  task automatic random_config;
    logic [47:0] mix;
    mix = {16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
           16'($urandom_range(0, 32768) - 16384)};
    if ($urandom_range(3) == 0) mix = {16'($urandom), $urandom};
    set_all($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 4000000), $urandom,
            27'($urandom_range(0, 134086656) >> $urandom_range(0, 9)),
            27'($urandom_range(0, 134086656) >> $urandom_range(0, 9)),
            16'($urandom_range(0, 32768) - 16384), 16'($urandom),
            17'($urandom_range(0, 131071)), mix);
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) random_config();
      src_idle = s_idle;
      snk_idle = r_idle;
      send_pair(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      left_line[i] = '0;
      right_line[i] = '0;
    end
    wr_pos = 0;
    lfo_ph = '0;
    damp_l = 0;
    damp_r = 0;
    m_phase_inc = 32'd447392;
    m_phase_off = '0;
    m_base = '0;
    m_sweep = '0;
    m_fb = '0;
    m_alpha = '0;
    m_shape = '0;
    m_mix = 48'd16384;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_settings();
    test_extremes();
    test_backpressure();
    test_random(300, 22, 77);
    test_random(300, 77, 22);
    test_random(300, 0, 0);
    drain();

    if (errors == 0) begin
      $display("stereo_flanger_tb: PASS");
    end else begin
      $display("stereo_flanger_tb: FAIL");
    end
    $finish;
  end

endmodule
